// ===== rtl/crc8fd_pkg.sv =====
package crc8fd_pkg;

    // Payload bytes covered by each check byte.
    localparam int unsigned CHUNK_BYTES = 8;
    localparam int unsigned CHUNK_W     = (CHUNK_BYTES > 2) ? $clog2(CHUNK_BYTES) : 1;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 1'd1;
    localparam logic [7:0] START_BYTE_RST = 8'd126;
    localparam logic [7:0] CRC_POLY_RST   = 8'd7;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRCERR  = 2'd2,
        KIND_ZEROLEN = 2'd3
    } t_kind;

    // Parser phases, one-hot.
    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } t_phase;

    // MSB-first CRC-8 of one byte, eight shift steps.
    function automatic logic [7:0] crc8_update(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/chunked_crc8_frame_decoder.sv =====
// Frame decoder for a byte stream: start byte, length byte, payload, with a
// CRC-8 check byte after every chunk of payload bytes and after the last
// partial chunk. Each chunk's CRC starts at zero.
// Input channel: i_valid / o_stall carry one received byte per request.
// Output channel: o_valid / i_stall carry at most one result per input byte:
// a payload byte with its index, frame good with its length, a checksum
// error or a zero length error.
// Configuration: i_cfg_valid / o_cfg_ready write the start byte (index 0) or
// the CRC polynomial (index 1); o_cfg_ready is always high.
// A result appears on the outputs in the cycle after its byte is accepted.
// Throughput is one byte per cycle unless the receiver stalls, set by the
// single result register which is refilled in the same cycle it is emptied.
// When the receiver stalls with a result held, o_stall rises and the held
// result stays unchanged until taken.
// Synchronous reset clears the parser to hunting, empties the result
// register and restores the register defaults (start 126, polynomial 7).
module chunked_crc8_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_kind,
    output logic [7:0]                        o_byte_value,
    output logic [7:0]                        o_byte_index,
    output logic [7:0]                        o_frame_length,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crc8fd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);

    logic [7:0]                      r_start_byte;
    logic [7:0]                      r_crc_poly;
    crc8fd_pkg::t_phase              r_phase, n_phase;
    logic [7:0]                      r_len, n_len;
    logic [7:0]                      r_count, n_count;
    logic [crc8fd_pkg::CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [7:0]                      r_crc, n_crc;
    logic                            r_out_valid;
    crc8fd_pkg::t_kind               r_kind, n_kind;
    logic [7:0]                      r_value, n_value;
    logic [7:0]                      r_index, n_index;
    logic [7:0]                      r_flen, n_flen;
    logic                            res_valid;
    logic                            in_accept;
    logic [7:0]                      crc_next;
    logic [7:0]                      count_inc;
    logic [crc8fd_pkg::CHUNK_W:0]    chunk_inc;

    // The result register accepts a new request unless it holds a stalled one.
    assign o_stall     = r_out_valid & i_stall;
    assign in_accept   = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    assign crc_next  = crc8fd_pkg::crc8_update(r_crc, i_rx_byte, r_crc_poly);
    assign count_inc = r_count + 8'd1;
    assign chunk_inc = {1'b0, r_chunk} + {{crc8fd_pkg::CHUNK_W{1'b0}}, 1'b1};

    // Parser step for one received byte.
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_count   = r_count;
        n_chunk   = r_chunk;
        n_crc     = r_crc;
        res_valid = 1'b0;
        n_kind    = crc8fd_pkg::KIND_BYTE;
        n_value   = 8'd0;
        n_index   = 8'd0;
        n_flen    = 8'd0;
        case (r_phase)
            crc8fd_pkg::PH_HUNT: begin
                if (i_rx_byte == r_start_byte) begin
                    n_len   = 8'd0;
                    n_count = 8'd0;
                    n_chunk = '0;
                    n_crc   = 8'd0;
                    n_phase = crc8fd_pkg::PH_LEN;
                end
            end
            crc8fd_pkg::PH_LEN: begin
                // A repeated start byte is skipped while waiting for the length.
                if (i_rx_byte != r_start_byte) begin
                    n_len = i_rx_byte;
                    if (i_rx_byte == 8'd0) begin
                        n_phase   = crc8fd_pkg::PH_HUNT;
                        res_valid = 1'b1;
                        n_kind    = crc8fd_pkg::KIND_ZEROLEN;
                    end else begin
                        n_phase = crc8fd_pkg::PH_DATA;
                    end
                end
            end
            crc8fd_pkg::PH_DATA: begin
                n_count   = count_inc;
                n_crc     = crc_next;
                res_valid = 1'b1;
                n_kind    = crc8fd_pkg::KIND_BYTE;
                n_value   = i_rx_byte;
                n_index   = r_count;
                if (chunk_inc == (crc8fd_pkg::CHUNK_W+1)'(crc8fd_pkg::CHUNK_BYTES)
                        || count_inc == r_len) begin
                    n_phase = crc8fd_pkg::PH_CHECK;
                    n_chunk = '0;
                end else begin
                    n_chunk = chunk_inc[crc8fd_pkg::CHUNK_W-1:0];
                end
            end
            crc8fd_pkg::PH_CHECK: begin
                if (i_rx_byte == r_crc) begin
                    if (r_count == r_len) begin
                        n_phase   = crc8fd_pkg::PH_HUNT;
                        res_valid = 1'b1;
                        n_kind    = crc8fd_pkg::KIND_GOOD;
                        n_flen    = r_len;
                    end else begin
                        n_phase = crc8fd_pkg::PH_DATA;
                        n_crc   = 8'd0;
                    end
                end else begin
                    n_phase   = crc8fd_pkg::PH_HUNT;
                    res_valid = 1'b1;
                    n_kind    = crc8fd_pkg::KIND_CRCERR;
                end
            end
            default: begin
                n_phase = crc8fd_pkg::PH_HUNT;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= crc8fd_pkg::START_BYTE_RST;
            r_crc_poly   <= crc8fd_pkg::CRC_POLY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crc8fd_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data;
                crc8fd_pkg::CFG_CRC_POLY:   r_crc_poly   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state, updated on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= crc8fd_pkg::PH_HUNT;
            r_len   <= 8'd0;
            r_count <= 8'd0;
            r_chunk <= '0;
            r_crc   <= 8'd0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
            r_chunk <= n_chunk;
            r_crc   <= n_crc;
        end
    end

    // Result register: loaded on accept, emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_index <= n_index;
            r_flen  <= n_flen;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_value   = r_value;
    assign o_byte_index   = r_index;
    assign o_frame_length = r_flen;

endmodule

// ===== rtl/crc8fd_checker.sv =====
module crc8fd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [1:0]                        o_kind,
    input logic [7:0]                        o_byte_value,
    input logic [7:0]                        o_byte_index,
    input logic [7:0]                        o_frame_length
);

    // After a reset cycle no result is offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

    // The input side only stalls behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // A stalled result is held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_byte_index)))
        else $error("stalled result changed");

    // Only a good frame carries a length, only a payload byte a value or index.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == crc8fd_pkg::KIND_GOOD || o_frame_length == 8'd0)
                     && (o_kind == crc8fd_pkg::KIND_BYTE
                         || (o_byte_value == 8'd0 && o_byte_index == 8'd0))))
        else $error("result fields inconsistent with kind");

    // A good frame taken by the receiver always carries a nonzero length.
    a_good_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_kind == crc8fd_pkg::KIND_GOOD)
            |-> (o_frame_length != 8'd0))
        else $error("good frame with zero length");

endmodule

bind chunked_crc8_frame_decoder crc8fd_checker u_crc8fd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_byte_value   (o_byte_value),
    .o_byte_index   (o_byte_index),
    .o_frame_length (o_frame_length)
);
